### rtl/heap_sort_engine_top_assert.svh
// Assertion macros for the heap sort engine RTL.
`ifndef HEAP_SORT_ENGINE_TOP_ASSERT_SVH
`define HEAP_SORT_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HSE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heap sort engine assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heap sort engine assertion failed");

`endif

### rtl/hse_pkg.sv
// Package for the heap sort engine: sizes, codes, payload and control structs.
`default_nettype none

package hse_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned WIDTH   = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PTR_W   = IDX_W + 2;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CMP_W   = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0] element_count;
    logic               sorted_done;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic read_issue;
    logic out_load;
    logic sort_init;
    logic rd_up;
    logic up_w1;
    logic up_w2;
    logic build_adv;
    logic ex_init;
    logic ex_rd;
    logic ex_w1;
    logic ex_w2;
    logic dn_rd;
    logic dn_w1;
    logic dn_w2;
    logic ex_dec;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic count_lt2;
    logic up_gt;
    logic parent_root;
    logic build_last;
    logic left_out;
    logic dn_gt;
    logic iter_one;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

### rtl/hse_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module hse_ram #(
  parameter int unsigned DATA_W    = 32,
  parameter int unsigned NUM_WORDS = 1024,
  localparam int unsigned ADDR_W   = $clog2(NUM_WORDS)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [NUM_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

### rtl/hse_ctrl.sv
// Controller state machine: input handshake and heapsort sequencing.
`default_nettype none

module hse_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [hse_pkg::MODE_W-1:0] mode_i,
  input  wire hse_pkg::status_t        status_i,
  output hse_pkg::cmd_t                cmd_o
);

  import hse_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0_0000_0000_0001,
    S_RD_OUT  = 13'b0_0000_0000_0010,
    S_UP_RD   = 13'b0_0000_0000_0100,
    S_UP_CMP  = 13'b0_0000_0000_1000,
    S_UP_W2   = 13'b0_0000_0001_0000,
    S_BLD_ADV = 13'b0_0000_0010_0000,
    S_EX_RD   = 13'b0_0000_0100_0000,
    S_EX_W1   = 13'b0_0000_1000_0000,
    S_EX_W2   = 13'b0_0001_0000_0000,
    S_DN_RD   = 13'b0_0010_0000_0000,
    S_DN_CMP  = 13'b0_0100_0000_0000,
    S_DN_W2   = 13'b0_1000_0000_0000,
    S_EX_ADV  = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) &&
                      ((mode_i != MODE_READ) || !status_i.out_busy);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_LOAD: begin
              cmd_o.load = 1'b1;
            end
            MODE_START: begin
              if (status_i.count_lt2) begin
                cmd_o.finish = 1'b1;
              end else begin
                cmd_o.sort_init = 1'b1;
                state_d         = S_UP_RD;
              end
            end
            MODE_READ: begin
              cmd_o.read_issue = 1'b1;
              state_d          = S_RD_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_OUT: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end
      S_UP_RD: begin
        cmd_o.rd_up = 1'b1;
        state_d     = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (status_i.up_gt) begin
          cmd_o.up_w1 = 1'b1;
          state_d     = S_UP_W2;
        end else begin
          state_d = S_BLD_ADV;
        end
      end
      S_UP_W2: begin
        cmd_o.up_w2 = 1'b1;
        state_d     = status_i.parent_root ? S_BLD_ADV : S_UP_RD;
      end
      S_BLD_ADV: begin
        if (status_i.build_last) begin
          cmd_o.ex_init = 1'b1;
          state_d       = S_EX_RD;
        end else begin
          cmd_o.build_adv = 1'b1;
          state_d         = S_UP_RD;
        end
      end
      S_EX_RD: begin
        cmd_o.ex_rd = 1'b1;
        state_d     = S_EX_W1;
      end
      S_EX_W1: begin
        cmd_o.ex_w1 = 1'b1;
        state_d     = S_EX_W2;
      end
      S_EX_W2: begin
        cmd_o.ex_w2 = 1'b1;
        state_d     = S_DN_RD;
      end
      S_DN_RD: begin
        if (status_i.left_out) begin
          state_d = S_EX_ADV;
        end else begin
          cmd_o.dn_rd = 1'b1;
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (status_i.dn_gt) begin
          cmd_o.dn_w1 = 1'b1;
          state_d     = S_DN_W2;
        end else begin
          state_d = S_EX_ADV;
        end
      end
      S_DN_W2: begin
        cmd_o.dn_w2 = 1'b1;
        state_d     = S_DN_RD;
      end
      S_EX_ADV: begin
        if (status_i.iter_one) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ex_dec = 1'b1;
          state_d      = S_EX_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/hse_dp.sv
// Datapath: element store, sort indices, flags and result register.
`default_nettype none
`include "heap_sort_engine_top_assert.svh"

module hse_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hse_pkg::in_item_t in_item_i,
  input  wire hse_pkg::cmd_t  cmd_i,
  output hse_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hse_pkg::out_item_t  out_item_o
);

  import hse_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic              done_q;
  logic              ovf_q;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  iter_q;
  logic [IDX_W-1:0]  bound_q;
  logic [IDX_W-1:0]  pick_q;
  logic [WIDTH-1:0]  held_q;
  logic              hit_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [IDX_W-1:0]  parent;
  logic [IDX_W:0]    cur_inc;
  logic [PTR_W-1:0]  left;
  logic [PTR_W-1:0]  right;
  logic [PTR_W-1:0]  bound_ext;
  logic              right_ok;
  logic              pick_r;
  logic [WIDTH-1:0]  pick_val;
  logic [IDX_W-1:0]  pick_idx;
  logic              full;
  logic              hit;

  logic              re;
  logic              we;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [IDX_W-1:0]  waddr;
  logic [WIDTH-1:0]  wdata;
  logic [WIDTH-1:0]  rdata_a;
  logic [WIDTH-1:0]  rdata_b;

  assign parent    = (cur_q - IDX_W'(1)) >> 1;
  assign cur_inc   = {1'b0, cur_q} + (IDX_W + 1)'(1);
  assign left      = {1'b0, cur_q, 1'b1};
  assign right     = {cur_inc, 1'b0};
  assign bound_ext = {2'b00, bound_q};
  assign right_ok  = right <= bound_ext;
  assign pick_r    = right_ok && (rdata_a < rdata_b);
  assign pick_val  = pick_r ? rdata_b : rdata_a;
  assign pick_idx  = pick_r ? right[IDX_W-1:0] : left[IDX_W-1:0];
  assign full      = count_q >= CNT_W'(DEPTH);
  assign hit       = CMP_W'(in_item_i.index) < CMP_W'(count_q);

  assign status_o.count_lt2   = count_q < CNT_W'(2);
  assign status_o.up_gt       = rdata_a > rdata_b;
  assign status_o.parent_root = parent == '0;
  assign status_o.build_last  = (CNT_W'(iter_q) + CNT_W'(1)) == count_q;
  assign status_o.left_out    = left > bound_ext;
  assign status_o.dn_gt       = pick_val > held_q;
  assign status_o.iter_one    = iter_q == IDX_W'(1);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign re = cmd_i.read_issue || cmd_i.rd_up || cmd_i.ex_rd || cmd_i.dn_rd;

  always_comb begin
    raddr_a = cur_q;
    raddr_b = parent;
    if (cmd_i.read_issue) begin
      raddr_a = IDX_W'(in_item_i.index);
    end else if (cmd_i.ex_rd) begin
      raddr_a = '0;
      raddr_b = iter_q;
    end else if (cmd_i.dn_rd) begin
      raddr_a = left[IDX_W-1:0];
      raddr_b = right[IDX_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = cur_q;
    wdata = rdata_b;
    if (cmd_i.load) begin
      we    = !full;
      waddr = count_q[IDX_W-1:0];
      wdata = WIDTH'(in_item_i.value);
    end else if (cmd_i.up_w1) begin
      waddr = parent;
      wdata = rdata_a;
    end else if (cmd_i.up_w2) begin
      waddr = cur_q;
      wdata = rdata_b;
    end else if (cmd_i.ex_w1) begin
      waddr = '0;
      wdata = rdata_b;
    end else if (cmd_i.ex_w2) begin
      waddr = iter_q;
      wdata = rdata_a;
    end else if (cmd_i.dn_w1) begin
      waddr = cur_q;
      wdata = pick_val;
    end else if (cmd_i.dn_w2) begin
      waddr = pick_q;
      wdata = held_q;
    end else begin
      we = 1'b0;
    end
  end

  hse_ram #(
    .DATA_W    (WIDTH),
    .NUM_WORDS (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      cur_q       <= '0;
      iter_q      <= '0;
      bound_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
          done_q  <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        done_q  <= 1'b1;
        bound_q <= '0;
        cur_q   <= '0;
      end
      if (cmd_i.sort_init) begin
        iter_q <= IDX_W'(1);
        cur_q  <= IDX_W'(1);
      end
      if (cmd_i.up_w2) begin
        cur_q <= parent;
      end
      if (cmd_i.build_adv) begin
        iter_q <= iter_q + IDX_W'(1);
        cur_q  <= iter_q + IDX_W'(1);
      end
      if (cmd_i.ex_init) begin
        iter_q <= IDX_W'(count_q - CNT_W'(1));
      end
      if (cmd_i.ex_w2) begin
        bound_q <= iter_q - IDX_W'(1);
        cur_q   <= '0;
      end
      if (cmd_i.dn_w2) begin
        cur_q <= pick_q;
      end
      if (cmd_i.ex_dec) begin
        iter_q <= iter_q - IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ex_w1) begin
      held_q <= rdata_b;
    end
    if (cmd_i.dn_w1) begin
      pick_q <= pick_idx;
    end
    if (cmd_i.read_issue) begin
      hit_q <= hit;
    end
    if (cmd_i.out_load) begin
      out_q.result_value  <= hit_q ? VALUE_W'(rdata_a) : '0;
      out_q.element_count <= COUNT_W'(count_q);
      out_q.sorted_done   <= done_q;
      out_q.overflow      <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `HSE_ASSERT(a_count_max, 1'b1, count_q <= CNT_W'(DEPTH))
  `HSE_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q)
  `HSE_ASSERT(a_out_source, $rose(out_valid_q), $past(cmd_i.out_load))
  `HSE_ASSERT(a_out_free, cmd_i.out_load, !out_valid_q)

endmodule

`default_nettype wire

### rtl/heap_sort_engine_top.sv
// Top level of the heap sort engine: controller plus datapath.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_item_i  (mode, value, index)
//   out      output     out_valid_o / out_ready_i out_item_o (value, count, flags)
//
// Load stores the value at the element count unless full; a read fetches the
// store, then loads the result register. Start finishes at once below two
// elements, else builds the heap by sifting up each element, then extracts
// each maximum and sifts down, each swap two writes on the single write port.
// Reset clears count and flags; store contents stay unknown until loaded.
// A read is held off while the result register holds an untaken transfer.
`default_nettype none

module heap_sort_engine_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hse_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hse_pkg::out_item_t     out_item_o
);

  import hse_pkg::*;

  cmd_t    cmd;
  status_t status;

  hse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (in_item_i.mode),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
